// ----- sv/bmmd_pkg.sv -----
// bmmd_pkg: shared constants for the banked memory map decoder
// op codes, read data sources, map addresses and store sizes
// no dependencies
package bmmd_pkg;

    localparam int unsigned BANK_BYTES = 32768;
    localparam int unsigned BANK_OFS_W = 15;
    localparam int unsigned ROM_DEPTH   = 16384;
    localparam int unsigned FIXED_DEPTH = 4096;
    localparam int unsigned VIDEO_DEPTH = 8192;
    localparam int unsigned ROM_AW   = 14;
    localparam int unsigned FIXED_AW = 12;
    localparam int unsigned VIDEO_AW = 13;

    typedef logic [1:0] t_op;
    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_LOAD  = 2'd2;

    typedef logic [2:0] t_src;
    localparam t_src SRC_ZERO  = 3'd0;
    localparam t_src SRC_REG   = 3'd1;
    localparam t_src SRC_ROM   = 3'd2;
    localparam t_src SRC_FIXED = 3'd3;
    localparam t_src SRC_VIDEO = 3'd4;
    localparam t_src SRC_BANK  = 3'd5;

    localparam logic [15:0] PORT_BANK    = 16'h4000;
    localparam logic [15:0] PORT_COUNT   = 16'h4001;
    localparam logic [15:0] PORT_CONSOLE = 16'h4002;

endpackage

// ----- sv/bmmd_ram.sv -----
// bmmd_ram: generic single-port synchronous ram, registered read
// depends on nothing
module bmmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/banked_memory_map_decoder.sv -----
// banked_memory_map_decoder: 16-bit bus decoder with rom, fixed, video and banked ram
// one transfer per accepted access, result in the cycle after the accept, one access per cycle while not busy
// the single ram port of each store sets that rate; the receiver cannot stall
// reset: bank select 0, bank count 1, then a clear of every video ram entry with busy high
// uses bmmd_pkg and bmmd_ram
module banked_memory_map_decoder
    import bmmd_pkg::*;
#(
    parameter int unsigned MAX_BANKS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [15:0] i_addr,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [7:0] o_rdata,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_taken,
    output logic       o_bank_fault
);

    localparam int unsigned BANK_DEPTH = MAX_BANKS * BANK_BYTES;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

    // control and config
    logic                r_clr_busy;
    logic [VIDEO_AW-1:0] r_clr_addr;
    logic [7:0]          r_bank_sel, n_bank_sel;
    logic [2:0]          r_bank_count;

    // result stage
    logic       r_valid;
    t_src       r_src, n_src;
    logic [7:0] r_reg_data, n_reg_data;
    logic       r_tx_valid, n_tx_valid;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic       r_rx_taken, n_rx_taken;
    logic       r_fault, n_fault;

    logic accept;
    logic is_rom, is_fixed, is_video, is_window, bank_ok;
    logic is_read, is_write, is_load;
    logic rom_we, fixed_we, video_we, bank_we;
    logic [VIDEO_AW-1:0] video_addr;
    logic [7:0]          video_wdata;
    logic [BANK_AW-1:0]  bank_addr;
    logic [BANK_OFS_W+7:0] bank_addr_full;
    logic [7:0] rom_q, fixed_q, video_q, bank_q;

    assign busy   = r_clr_busy;
    assign accept = start && !busy;

    assign is_read   = (i_op == OP_READ);
    assign is_write  = (i_op == OP_WRITE);
    assign is_load   = (i_op == OP_LOAD);
    assign is_rom    = (i_addr[15:14] == 2'b00);
    assign is_fixed  = (i_addr[15:12] == 4'h5);
    assign is_video  = (i_addr[15:13] == 3'b011);
    assign is_window = i_addr[15];
    assign bank_ok   = ({1'b0, r_bank_sel} < {6'd0, r_bank_count})
                    && ({1'b0, r_bank_sel} < 9'(MAX_BANKS));

    assign rom_we   = accept && is_load && is_rom;
    assign fixed_we = accept && is_write && is_fixed;
    assign bank_we  = accept && is_write && is_window && bank_ok;
    // the clear pass owns the video port until it finishes
    assign video_we    = r_clr_busy || (accept && is_write && is_video);
    assign video_addr  = r_clr_busy ? r_clr_addr : i_addr[VIDEO_AW-1:0];
    assign video_wdata = r_clr_busy ? 8'd0 : i_wdata;

    assign bank_addr_full = {r_bank_sel, i_addr[BANK_OFS_W-1:0]};
    assign bank_addr      = bank_addr_full[BANK_AW-1:0];

    bmmd_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .i_clk  (i_clk),
        .i_we   (rom_we),
        .i_addr (i_addr[ROM_AW-1:0]),
        .i_wdata(i_wdata),
        .o_rdata(rom_q)
    );

    bmmd_ram #(.WIDTH(8), .DEPTH(FIXED_DEPTH)) u_fixed (
        .i_clk  (i_clk),
        .i_we   (fixed_we),
        .i_addr (i_addr[FIXED_AW-1:0]),
        .i_wdata(i_wdata),
        .o_rdata(fixed_q)
    );

    bmmd_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video (
        .i_clk  (i_clk),
        .i_we   (video_we),
        .i_addr (video_addr),
        .i_wdata(video_wdata),
        .o_rdata(video_q)
    );

    bmmd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
        .i_clk  (i_clk),
        .i_we   (bank_we),
        .i_addr (bank_addr),
        .i_wdata(i_wdata),
        .o_rdata(bank_q)
    );

    always_comb begin
        n_src      = SRC_ZERO;
        n_reg_data = 8'd0;
        n_tx_valid = 1'b0;
        n_tx_byte  = 8'd0;
        n_rx_taken = 1'b0;
        n_fault    = 1'b0;
        n_bank_sel = r_bank_sel;
        if (accept && is_read) begin
            if (is_rom) begin
                n_src = SRC_ROM;
            end else if (i_addr == PORT_BANK) begin
                n_src      = SRC_REG;
                n_reg_data = r_bank_sel;
            end else if (i_addr == PORT_COUNT) begin
                n_src      = SRC_REG;
                n_reg_data = {5'd0, r_bank_count};
            end else if (i_addr == PORT_CONSOLE) begin
                n_src      = SRC_REG;
                n_reg_data = i_rx_byte;
                n_rx_taken = 1'b1;
            end else if (is_fixed) begin
                n_src = SRC_FIXED;
            end else if (is_video) begin
                n_src = SRC_VIDEO;
            end else if (is_window) begin
                if (bank_ok) begin
                    n_src = SRC_BANK;
                end else begin
                    n_fault = 1'b1;
                end
            end
        end else if (accept && is_write) begin
            if (i_addr == PORT_BANK) begin
                n_bank_sel = i_wdata;
            end else if (i_addr == PORT_CONSOLE) begin
                n_tx_valid = 1'b1;
                n_tx_byte  = i_wdata;
            end else if (is_window && !bank_ok) begin
                n_fault = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_bank_sel   <= 8'd0;
            r_bank_count <= 3'd1;
            r_valid      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {VIDEO_AW{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_bank_count <= i_cfg_wdata;
            end
            r_bank_sel <= n_bank_sel;
            r_valid    <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_reg_data <= n_reg_data;
        r_tx_valid <= n_tx_valid;
        r_tx_byte  <= n_tx_byte;
        r_rx_taken <= n_rx_taken;
        r_fault    <= n_fault;
    end

    always_comb begin
        case (r_src)
            SRC_REG:   o_rdata = r_reg_data;
            SRC_ROM:   o_rdata = rom_q;
            SRC_FIXED: o_rdata = fixed_q;
            SRC_VIDEO: o_rdata = video_q;
            SRC_BANK:  o_rdata = bank_q;
            default:   o_rdata = 8'd0;
        endcase
    end

    assign o_valid      = r_valid;
    assign o_tx_valid   = r_tx_valid;
    assign o_tx_byte    = r_tx_byte;
    assign o_rx_taken   = r_rx_taken;
    assign o_bank_fault = r_fault;

    // a result transfer always comes in the cycle after an accepted access
    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy))
        else $error("result without a preceding accept");

    // console and fault flags never combine in one result
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_tx_valid, o_rx_taken, o_bank_fault}) <= 1))
        else $error("conflicting result flags");

    // no result may appear while the video clear pass runs
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result during video clear");

    // a faulting access leaves the banked store untouched
    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_window && !bank_ok) |-> !bank_we)
        else $error("write to absent bank");

endmodule
